// ===== hw/rtl/exp_pulse_shape_generator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// exp pulse shape generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EXP_PULSE_SHAPE_GENERATOR_UNIT_MACROS_SVH
`define EXP_PULSE_SHAPE_GENERATOR_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define EPSG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("epsg assertion failed");

// consequent checked in the next cycle
`define EPSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("epsg assertion failed");

`endif

// ===== hw/rtl/epsg_pkg.sv =====
// ----------------------------------------------------------------------------
// epsg_pkg
// Widths, constants and shared types of the exp pulse shape generator.
// ----------------------------------------------------------------------------
package epsg_pkg;

  localparam int TIME_BITS      = 32;
  localparam int TIME_FRAC_BITS = 12;
  localparam int AMP_BITS       = 24;
  localparam int EXP_FRAC_BITS  = 16;

  localparam int BASE_BITS    = 24;
  localparam int CFG_BITS     = 32;
  localparam int CFG_IDX_BITS = 8;
  localparam int OUT_BITS     = 32;

  localparam int Q30      = 30;
  localparam int A_BITS   = Q30 + 1;
  localparam int W_BITS   = Q30;
  localparam int CMP_BITS = ((TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS) + 1;

  localparam int PROD_BITS = TIME_BITS + CFG_BITS;
  localparam int X_SHIFT   = 32 + TIME_FRAC_BITS - EXP_FRAC_BITS;
  localparam int X_BITS    = 5 + EXP_FRAC_BITS;
  localparam int FLUSH_LSB = 37 + TIME_FRAC_BITS;
  localparam int Y_BITS    = X_BITS + 1;
  localparam int K_BITS    = Y_BITS - EXP_FRAC_BITS;
  localparam int SH_BITS   = K_BITS + 1;
  localparam int SH_MAX    = 40;
  localparam int RND_BITS  = SH_MAX + 2;
  localparam int E_BITS    = EXP_FRAC_BITS + 1;
  localparam int MIX_BITS  = AMP_BITS + E_BITS + 1;
  localparam int SUM_BITS  =
    ((MIX_BITS > BASE_BITS + EXP_FRAC_BITS) ? MIX_BITS : BASE_BITS + EXP_FRAC_BITS) + 1;
  localparam int RES_BITS  = SUM_BITS - EXP_FRAC_BITS;
  localparam int SAT_BITS  = (RES_BITS > OUT_BITS + 1) ? RES_BITS : OUT_BITS + 1;

  localparam int HORNER_ORDER = 8;
  localparam int RCP_SHIFT    = 33;
  localparam int RCP_BITS     = RCP_SHIFT + 1;

  localparam logic [30:0]       LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0]       LN2_Q30   = 30'd744261118;
  localparam logic [A_BITS-1:0] ONE_Q30   = {1'b1, {Q30{1'b0}}};
  localparam logic [E_BITS-1:0] ONE_E     = {1'b1, {EXP_FRAC_BITS{1'b0}}};

  // ceil(2^33 / j), exact floor division for 30-bit dividends
  localparam logic [RCP_BITS-1:0] RCP_BY_DIV [1:HORNER_ORDER] = '{
    34'd8589934592, 34'd4294967296, 34'd2863311531, 34'd2147483648,
    34'd1717986919, 34'd1431655766, 34'd1227133514, 34'd1073741824
  };

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BASELINE = 8'd0,
    REG_INV_RISE = 8'd1,
    REG_INV_FALL = 8'd2,
    REG_RISE_LEN = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [BASE_BITS-1:0] baseline;
    logic [CFG_BITS-1:0]         inv_rise;
    logic [CFG_BITS-1:0]         inv_fall;
    logic [CFG_BITS-1:0]         rise_len;
  } cfg_t;

  typedef struct packed {
    logic                       pre_start;
    logic                       rise;
    logic                       flush;
    logic signed [AMP_BITS-1:0] amp;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [PROD_BITS-1:0] p;
  } front_t;

  typedef struct packed {
    side_t             side;
    logic [K_BITS-1:0] k;
    logic [A_BITS-1:0] a;
  } horn_t;

endpackage

// ===== hw/rtl/epsg_front.sv =====
// ----------------------------------------------------------------------------
// epsg_front
// Segment selection and exponent argument product, three stages.
// ----------------------------------------------------------------------------
module epsg_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [epsg_pkg::TIME_BITS-1:0]       sample_time,
  input  logic signed [epsg_pkg::AMP_BITS-1:0] pulse_amplitude,
  input  logic [epsg_pkg::TIME_BITS-1:0]       pulse_start,
  input  epsg_pkg::cfg_t                       cfg,
  output logic                                 out_valid,
  output epsg_pkg::front_t                     out_data
);

  localparam int TB = epsg_pkg::TIME_BITS;
  localparam int CB = epsg_pkg::CMP_BITS;

  logic [2:0] v_r;

  logic [TB:0]                  diff0;
  logic [TB-1:0]                dt_r;
  epsg_pkg::side_t              side0_nxt, side0_r;

  logic [CB-1:0]                diff1;
  logic [TB-1:0]                d_nxt, d_r;
  logic [epsg_pkg::CFG_BITS-1:0] inv_nxt, inv_r;
  epsg_pkg::side_t              side1_nxt, side1_r;

  epsg_pkg::front_t             fr_nxt, fr_r;

  always_comb begin
    diff0               = {1'b0, sample_time} - {1'b0, pulse_start};
    side0_nxt.pre_start = diff0[TB];
    side0_nxt.rise      = 1'b0;
    side0_nxt.flush     = 1'b0;
    side0_nxt.amp       = pulse_amplitude;
  end

  always_comb begin
    diff1          = CB'(dt_r) - CB'(cfg.rise_len);
    side1_nxt      = side0_r;
    side1_nxt.rise = diff1[CB-1];
    d_nxt          = diff1[CB-1] ? dt_r : diff1[TB-1:0];
    inv_nxt        = diff1[CB-1] ? cfg.inv_rise : cfg.inv_fall;
  end

  always_comb begin
    fr_nxt.side = side1_r;
    fr_nxt.p    = epsg_pkg::PROD_BITS'(d_r) * epsg_pkg::PROD_BITS'(inv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dt_r    <= diff0[TB-1:0];
      side0_r <= side0_nxt;
      d_r     <= d_nxt;
      inv_r   <= inv_nxt;
      side1_r <= side1_nxt;
      fr_r    <= fr_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign out_data  = fr_r;

endmodule

// ===== hw/rtl/epsg_horner.sv =====
// ----------------------------------------------------------------------------
// epsg_horner
// Base-2 range reduction and eighth-order Horner chain for exp(-w) in Q.30.
// ----------------------------------------------------------------------------
module epsg_horner (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  epsg_pkg::front_t in_data,
  output logic             out_valid,
  output epsg_pkg::horn_t  out_data
);

  localparam int NSTEP   = 2 * epsg_pkg::HORNER_ORDER;
  localparam int NORD    = epsg_pkg::HORNER_ORDER;
  localparam int EF      = epsg_pkg::EXP_FRAC_BITS;
  localparam int YP_BITS = epsg_pkg::X_BITS + 32;
  localparam int WP_BITS = EF + epsg_pkg::Q30;
  localparam int MP_BITS = epsg_pkg::W_BITS + epsg_pkg::A_BITS;
  localparam int QP_BITS = epsg_pkg::W_BITS + epsg_pkg::RCP_BITS;

  typedef struct packed {
    epsg_pkg::side_t                  side;
    logic [epsg_pkg::K_BITS-1:0]      k;
    logic [epsg_pkg::W_BITS-1:0]      w;
    logic [epsg_pkg::A_BITS-1:0]      a;
    logic [epsg_pkg::W_BITS-1:0]      m;
  } step_t;

  logic [1:0]       hv_r;
  logic [NSTEP-1:0] sv_r;

  logic [epsg_pkg::X_BITS-1:0]  x;
  logic [YP_BITS-1:0]           yp_nxt, yp_r;
  epsg_pkg::side_t              side0_nxt, side0_r;

  logic [epsg_pkg::Y_BITS-1:0]  y;
  logic [WP_BITS-1:0]           wp;
  logic [epsg_pkg::W_BITS-1:0]  w_r;
  logic [epsg_pkg::K_BITS-1:0]  k_r;
  epsg_pkg::side_t              side1_r;

  step_t              step_src [NORD];
  logic [MP_BITS-1:0] mprod    [NORD];
  logic [QP_BITS-1:0] qprod    [NORD];
  step_t              st_nxt   [NSTEP];
  step_t              st_r     [NSTEP];

  always_comb begin
    x               = in_data.p[epsg_pkg::X_SHIFT +: epsg_pkg::X_BITS];
    side0_nxt       = in_data.side;
    side0_nxt.flush = |in_data.p[epsg_pkg::PROD_BITS-1:epsg_pkg::FLUSH_LSB];
    yp_nxt          = YP_BITS'(x) * YP_BITS'(epsg_pkg::LOG2E_Q30)
                    + (YP_BITS'(1) << (epsg_pkg::Q30 - 1));
  end

  always_comb begin
    y  = yp_r[epsg_pkg::Q30 +: epsg_pkg::Y_BITS];
    wp = WP_BITS'(y[EF-1:0]) * WP_BITS'(epsg_pkg::LN2_Q30);
  end

  always_comb begin
    step_src[0].side = side1_r;
    step_src[0].k    = k_r;
    step_src[0].w    = w_r;
    step_src[0].a    = epsg_pkg::ONE_Q30;
    step_src[0].m    = '0;
    for (int i = 1; i < NORD; i++) begin
      step_src[i] = st_r[2 * i - 1];
    end
    for (int i = 0; i < NORD; i++) begin
      // multiply stage: m = w * a in Q.30
      mprod[i]         = MP_BITS'(step_src[i].w) * MP_BITS'(step_src[i].a);
      st_nxt[2 * i]    = step_src[i];
      st_nxt[2 * i].m  = mprod[i][epsg_pkg::Q30 +: epsg_pkg::W_BITS];
      // divide stage: a = 1 - m / j by reciprocal
      qprod[i]          = QP_BITS'(st_r[2 * i].m)
                        * QP_BITS'(epsg_pkg::RCP_BY_DIV[NORD - i]);
      st_nxt[2 * i + 1]   = st_r[2 * i];
      st_nxt[2 * i + 1].a = epsg_pkg::ONE_Q30
                          - epsg_pkg::A_BITS'(qprod[i][epsg_pkg::RCP_SHIFT +: epsg_pkg::W_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
      sv_r <= '0;
    end else if (en) begin
      hv_r <= {hv_r[0], in_valid};
      sv_r <= {sv_r[NSTEP-2:0], hv_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yp_r    <= yp_nxt;
      side0_r <= side0_nxt;
      w_r     <= wp[EF +: epsg_pkg::W_BITS];
      k_r     <= y[EF +: epsg_pkg::K_BITS];
      side1_r <= side0_r;
      for (int s = 0; s < NSTEP; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign out_valid     = sv_r[NSTEP-1];
  assign out_data.side = st_r[NSTEP-1].side;
  assign out_data.k    = st_r[NSTEP-1].k;
  assign out_data.a    = st_r[NSTEP-1].a;

endmodule

// ===== hw/rtl/epsg_back.sv =====
// ----------------------------------------------------------------------------
// epsg_back
// Exponent scaling, amplitude mix, rounding, saturation and output skid.
// ----------------------------------------------------------------------------
module epsg_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  output logic                                  en,
  input  logic                                  in_valid,
  input  epsg_pkg::horn_t                       in_data,
  input  logic signed [epsg_pkg::BASE_BITS-1:0] baseline,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [epsg_pkg::OUT_BITS-1:0]  sample_value
);

  localparam int EF  = epsg_pkg::EXP_FRAC_BITS;
  localparam int SB  = epsg_pkg::SUM_BITS;
  localparam int STB = epsg_pkg::SAT_BITS;
  localparam logic signed [STB-1:0] SAT_HI =
    STB'({1'b0, {(epsg_pkg::OUT_BITS-1){1'b1}}});
  localparam logic signed [STB-1:0] SAT_LO = ~SAT_HI;

  logic [1:0] bv_r;

  logic [epsg_pkg::SH_BITS-1:0]  sh;
  logic [epsg_pkg::RND_BITS-1:0] rnd;
  logic [epsg_pkg::E_BITS-1:0]   e;
  logic [epsg_pkg::E_BITS-1:0]   g_nxt, g_r;
  epsg_pkg::side_t               side0_r, side1_r;

  logic signed [epsg_pkg::MIX_BITS-1:0] mix_nxt, mix_r;

  logic signed [SB-1:0]                 base_s;
  logic signed [SB-1:0]                 sum;
  logic signed [epsg_pkg::RES_BITS-1:0] res;
  logic signed [STB-1:0]                res_x;
  logic signed [epsg_pkg::OUT_BITS-1:0] value_nxt;

  logic                                 arrive;
  logic                                 out_v_nxt, out_v_r, sk_v_nxt, sk_v_r;
  logic signed [epsg_pkg::OUT_BITS-1:0] out_d_nxt, out_d_r, sk_d_nxt, sk_d_r;

  always_comb begin
    sh  = epsg_pkg::SH_BITS'(epsg_pkg::Q30 - EF) + epsg_pkg::SH_BITS'(in_data.k);
    rnd = epsg_pkg::RND_BITS'(in_data.a)
        + (epsg_pkg::RND_BITS'(1) << (sh - epsg_pkg::SH_BITS'(1)));
    if (in_data.side.flush || (sh > epsg_pkg::SH_BITS'(epsg_pkg::SH_MAX))) begin
      e = '0;
    end else begin
      e = epsg_pkg::E_BITS'(rnd >> sh);
    end
    g_nxt = in_data.side.rise ? (epsg_pkg::ONE_E - e) : e;
  end

  always_comb begin
    mix_nxt = epsg_pkg::MIX_BITS'(side0_r.amp)
            * epsg_pkg::MIX_BITS'(signed'({1'b0, g_r}));
  end

  always_comb begin
    base_s = SB'(baseline);
    sum    = (base_s <<< EF) + SB'(mix_r) + (SB'(1) << (EF - 1));
    res    = sum[SB-1:EF];
    res_x  = STB'(res);
    priority if (side1_r.pre_start) begin
      value_nxt = '0;
    end else if (res_x > SAT_HI) begin
      value_nxt = SAT_HI[epsg_pkg::OUT_BITS-1:0];
    end else if (res_x < SAT_LO) begin
      value_nxt = SAT_LO[epsg_pkg::OUT_BITS-1:0];
    end else begin
      value_nxt = res_x[epsg_pkg::OUT_BITS-1:0];
    end
  end

  assign en     = !sk_v_r;
  assign arrive = en && bv_r[1];

  // output register with a one-entry skid behind it
  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    sk_v_nxt  = sk_v_r;
    sk_d_nxt  = sk_d_r;
    if (!out_v_r || !out_stall) begin
      if (sk_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = sk_d_r;
        sk_v_nxt  = 1'b0;
      end else begin
        out_v_nxt = arrive;
        out_d_nxt = value_nxt;
      end
    end else if (arrive) begin
      sk_v_nxt = 1'b1;
      sk_d_nxt = value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r    <= '0;
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      if (en) begin
        bv_r <= {bv_r[0], in_valid};
      end
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r     <= g_nxt;
      side0_r <= in_data.side;
      mix_r   <= mix_nxt;
      side1_r <= side0_r;
    end
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

  assign out_valid    = out_v_r;
  assign sample_value = out_d_r;

endmodule

// ===== hw/rtl/exp_pulse_shape_generator_unit.sv =====
// ----------------------------------------------------------------------------
// exp_pulse_shape_generator_unit
// Exponential pulse shape evaluated at one time point per transfer.
// ----------------------------------------------------------------------------
// Takes one input transfer per clock while in_stall is low and returns one
// result per input, in order. The exponential path holds a 32x32 argument
// product, the base-2 range reduction and an eighth-order Horner chain that
// spends two stages per term (multiply, then exact divide by reciprocal). A
// stalled output lets one more item drain into a skid entry; in_stall
// then rises in the following cycle and falls again once the output
// register's result is transferred and the skid entry moves into it.
// Configuration writes are taken at any time with cfg_ready held high and
// must only happen while no item is in flight; unknown indexes are ignored.
module exp_pulse_shape_generator_unit (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [epsg_pkg::TIME_BITS-1:0]            in_sample_time,
  input  logic signed [epsg_pkg::AMP_BITS-1:0]      in_pulse_amplitude,
  input  logic [epsg_pkg::TIME_BITS-1:0]            in_pulse_start,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [epsg_pkg::OUT_BITS-1:0]      out_sample_value,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [epsg_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [epsg_pkg::CFG_BITS-1:0]             cfg_data
);

  epsg_pkg::cfg_t   cfg_r;
  logic             pipe_en;
  logic             fr_valid, hn_valid;
  epsg_pkg::front_t fr_data;
  epsg_pkg::horn_t  hn_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = !pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        epsg_pkg::REG_BASELINE: cfg_r.baseline <= cfg_data[epsg_pkg::BASE_BITS-1:0];
        epsg_pkg::REG_INV_RISE: cfg_r.inv_rise <= cfg_data;
        epsg_pkg::REG_INV_FALL: cfg_r.inv_fall <= cfg_data;
        epsg_pkg::REG_RISE_LEN: cfg_r.rise_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  epsg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (pipe_en),
    .in_valid        (in_valid),
    .sample_time     (in_sample_time),
    .pulse_amplitude (in_pulse_amplitude),
    .pulse_start     (in_pulse_start),
    .cfg             (cfg_r),
    .out_valid       (fr_valid),
    .out_data        (fr_data)
  );

  epsg_horner u_horner (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (fr_valid),
    .in_data   (fr_data),
    .out_valid (hn_valid),
    .out_data  (hn_data)
  );

  epsg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (pipe_en),
    .in_valid     (hn_valid),
    .in_data      (hn_data),
    .baseline     (cfg_r.baseline),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_value (out_sample_value)
  );

endmodule

// ===== hw/rtl/epsg_checker.sv =====
// ----------------------------------------------------------------------------
// epsg_checker
// Port-level assertions for the exp pulse shape generator, bound to the top.
// ----------------------------------------------------------------------------
`include "exp_pulse_shape_generator_unit_macros.svh"

module epsg_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [epsg_pkg::OUT_BITS-1:0] out_sample_value,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready
);

  localparam int CNT_BITS = 6;

  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  // items accepted but not yet transferred out
  always_comb begin
    cnt_nxt = cnt_r + CNT_BITS'(in_valid && !in_stall) - CNT_BITS'(out_valid && !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `EPSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample_value))
  `EPSG_ASSERT_NOW(a_no_invented, cnt_r == '0, !out_valid)
  `EPSG_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid)
  `EPSG_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall))
  `EPSG_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind exp_pulse_shape_generator_unit epsg_checker u_epsg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample_value (out_sample_value),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready)
);
